// ===== rtl/rpn_pkg.sv =====
// Shared types, command codes and status bits of the RPN stack calculator.
package rpn_pkg;

  localparam int DefaultDepth = 128;
  localparam int WordW = 32;
  localparam int KindW = 4;
  localparam int StatW = 4;

  localparam logic [KindW-1:0] KIND_PUSH  = 4'd0;
  localparam logic [KindW-1:0] KIND_ADD   = 4'd1;
  localparam logic [KindW-1:0] KIND_SUB   = 4'd2;
  localparam logic [KindW-1:0] KIND_MUL   = 4'd3;
  localparam logic [KindW-1:0] KIND_DIV   = 4'd4;
  localparam logic [KindW-1:0] KIND_MOD   = 4'd5;
  localparam logic [KindW-1:0] KIND_PRINT = 4'd6;
  localparam logic [KindW-1:0] KIND_PEEK  = 4'd7;
  localparam logic [KindW-1:0] KIND_DUP   = 4'd8;
  localparam logic [KindW-1:0] KIND_SWAP  = 4'd9;
  localparam logic [KindW-1:0] KIND_CLEAR = 4'd10;

  localparam int ST_UNDER = 0;
  localparam int ST_FULL  = 1;
  localparam int ST_ZDIV  = 2;
  localparam int ST_SWAP  = 3;

  // Request from the sequencer to the divide unit.
  typedef struct packed {
    logic              start;
    logic              is_mod;
    logic signed [WordW-1:0] num;
    logic signed [WordW-1:0] den;
  } div_req_t;

  // Answer of the divide unit.
  typedef struct packed {
    logic              done;
    logic [WordW-1:0]  res;
  } div_rsp_t;

  // Saturate a 64-bit signed value to 32 bits.
  function automatic logic [WordW-1:0] sat32(input logic signed [63:0] v);
    logic [WordW-1:0] r;
    if (v > 64'sd2147483647) r = 32'h7fffffff;
    else if (v < -64'sd2147483648) r = 32'h80000000;
    else r = v[WordW-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/rpn_stack_calculator.sv =====
// Top level of the RPN stack calculator.
// One command is taken at a time and gives exactly one result item. All
// kinds read the stack in RD1 and RD2 and are decided in EXEC. Push, print,
// peek, dup, clear, unused kinds, and a divide with an empty stack or a zero
// divisor end there; swap goes on through WR2, add/sub/mul through PROD and
// MUL, and divide and remainder wait on the one-bit-per-cycle divider (48
// quotient bits for divide, 32 for remainder). The next item can be accepted
// in the cycle after the result is taken. The stack is a single-port-read
// memory of DEPTH words, registered read; underflowed operands read as zero.
module rpn_stack_calculator #(
  parameter int DEPTH = rpn_pkg::DefaultDepth
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rpn_pkg::KindW-1:0] kind,
  input  logic signed [31:0]        value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      shown,
  output logic signed [31:0]        result_value,
  output logic [rpn_pkg::StatW-1:0] status
);

  rpn_pkg::div_req_t dreq;
  rpn_pkg::div_rsp_t drsp;

  rpn_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .kind, .value,
    .out_valid, .out_ready, .shown, .result_value, .status,
    .dreq, .drsp
  );

  rpn_div u_div (.clk, .rst, .req(dreq), .rsp(drsp));

endmodule

// ===== rtl/rpn_div.sv =====
// Radix-2 restoring divider for Q16.16 divide and truncated remainder.
module rpn_div (
  input  logic              clk,
  input  logic              rst,
  input  rpn_pkg::div_req_t req,
  output rpn_pkg::div_rsp_t rsp
);

  logic        busy;
  logic [5:0]  cnt;
  logic [47:0] dvd;
  logic [32:0] rem;
  logic [31:0] dsr;
  logic        neg_q;
  logic        neg_r;
  logic        is_mod;
  logic        fin;
  logic [32:0] trial;
  logic signed [63:0] q_s;
  logic signed [63:0] r_s;

  assign trial = {rem[31:0], dvd[47]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        is_mod <= req.is_mod;
        neg_r  <= req.num[31];
        neg_q  <= req.num[31] ^ req.den[31];
        dsr    <= req.den[31] ? 32'(-req.den) : req.den;
        // Divide runs over the dividend scaled by 2^16; remainder over the raw word only.
        if (req.is_mod) begin
          dvd <= {(req.num[31] ? 32'(-req.num) : req.num), 16'd0};
          cnt <= 6'd32;
        end else begin
          dvd <= {(req.num[31] ? 32'(-req.num) : req.num), 16'd0};
          cnt <= 6'd48;
        end
        rem <= '0;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          dvd <= {dvd[46:0], 1'b1};
        end else begin
          rem <= {rem[31:0], dvd[47]};
          dvd <= {dvd[46:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  // Sign fix-up of the finished quotient or remainder, and saturation of the quotient.
  always_comb begin
    q_s = neg_q ? -$signed({16'd0, dvd}) : $signed({16'd0, dvd});
    r_s = neg_r ? -$signed({31'd0, rem}) : $signed({31'd0, rem});
    rsp.done = fin;
    rsp.res  = is_mod ? r_s[31:0] : rpn_pkg::sat32(q_s);
  end

endmodule

// ===== rtl/rpn_ctrl.sv =====
// Command sequencer: reads, modifies and writes back the stack memory.
module rpn_ctrl #(
  parameter int DEPTH = rpn_pkg::DefaultDepth
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [rpn_pkg::KindW-1:0] kind,
  input  logic signed [31:0]       value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     shown,
  output logic signed [31:0]       result_value,
  output logic [rpn_pkg::StatW-1:0] status,
  output rpn_pkg::div_req_t        dreq,
  input  rpn_pkg::div_rsp_t        drsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] CMAX = CW'(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_WR2  = 3'd6;
  localparam logic [2:0] S_PROD = 3'd7;

  logic signed [31:0] mem [DEPTH];
  logic [31:0]        rdata;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [31:0]        wdata;
  logic [AW-1:0]      raddr;

  logic [2:0]         state;
  logic [CW-1:0]      count;
  logic [3:0]         k;
  logic [31:0]        val;
  logic signed [31:0] opa;
  logic signed [31:0] opb;
  logic signed [63:0] prod;

  // Stack memory, one write and one registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      we        <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      we <= 1'b0;
      dreq.start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            k   <= kind;
            val <= value;
            opa <= '0;
            opb <= '0;
            raddr <= AW'(count - 1'b1);
            state <= S_RD1;
          end
        end
        S_RD1: begin
          // Top entry arrives next cycle; issue second entry address.
          raddr <= AW'(count - 2'd2);
          state <= S_RD2;
        end
        S_RD2: begin
          opb   <= (count != 0) ? rdata : 32'd0;
          state <= S_EXEC;
        end
        S_EXEC: begin
          opa <= (count > 1) ? rdata : 32'd0;
          state <= S_IDLE;
          shown <= 1'b0;
          result_value <= '0;
          out_valid <= 1'b1;
          unique case (k)
            rpn_pkg::KIND_PUSH: begin
              if (count < CMAX) begin
                we <= 1'b1; waddr <= AW'(count); wdata <= val;
                count <= count + 1'b1;
              end else status <= 4'b0010;
              if (count < CMAX) status <= '0;
            end
            rpn_pkg::KIND_ADD, rpn_pkg::KIND_SUB, rpn_pkg::KIND_MUL: begin
              out_valid <= 1'b0;
              state <= S_PROD;
            end
            rpn_pkg::KIND_DIV, rpn_pkg::KIND_MOD: begin
              if (count == 0 || opb == 0) begin
                status <= {1'b0, 1'b1, 1'b0, count == 0};
                if (count != 0) count <= count - 1'b1;
              end else begin
                out_valid <= 1'b0;
                dreq.start  <= 1'b1;
                dreq.is_mod <= (k == rpn_pkg::KIND_MOD);
                dreq.num    <= (count > 1) ? rdata : 32'd0;
                dreq.den    <= opb;
                state <= S_DIV;
              end
            end
            rpn_pkg::KIND_PRINT, rpn_pkg::KIND_PEEK: begin
              shown <= 1'b1;
              result_value <= opb;
              status <= {3'b000, count == 0};
              if (k == rpn_pkg::KIND_PRINT && count != 0) count <= count - 1'b1;
            end
            rpn_pkg::KIND_DUP: begin
              if (count == 0) status <= 4'b0001;
              else if (count >= CMAX) status <= 4'b0010;
              else begin
                status <= '0;
                we <= 1'b1; waddr <= AW'(count); wdata <= opb;
                count <= count + 1'b1;
              end
            end
            rpn_pkg::KIND_SWAP: begin
              if (count > 1) begin
                status <= '0;
                we <= 1'b1; waddr <= AW'(count - 1'b1); wdata <= rdata;
                state <= S_WR2;
                out_valid <= 1'b0;
              end else status <= 4'b1000;
            end
            rpn_pkg::KIND_CLEAR: begin
              count <= '0; status <= '0;
            end
            default: status <= '0;
          endcase
        end
        S_PROD: begin
          // The left operand is now settled; the product register loads here.
          state <= S_MUL;
        end
        S_MUL: begin
          // Add, subtract or multiply, then push the saturated result.
          logic [31:0] r;
          logic [1:0]  pops;
          logic [CW-1:0] c2;
          pops = (count > 1) ? 2'd2 : ((count == 1) ? 2'd1 : 2'd0);
          c2 = count - CW'(pops);
          if (k == rpn_pkg::KIND_ADD)
            r = rpn_pkg::sat32(64'(opa) + 64'(opb));
          else if (k == rpn_pkg::KIND_SUB)
            r = rpn_pkg::sat32(64'(opa) - 64'(opb));
          else
            r = rpn_pkg::sat32(prod / 64'sd65536);
          we <= 1'b1; waddr <= AW'(c2); wdata <= r;
          count <= c2 + 1'b1;
          status <= {3'b000, count < 2};
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_DIV: begin
          // With a single entry the left operand underflows and the result
          // replaces the divisor in place.
          if (drsp.done) begin
            we <= 1'b1; wdata <= drsp.res;
            if (count > 1) begin
              waddr <= AW'(count - 2'd2);
              count <= count - 1'b1;
              status <= '0;
            end else begin
              waddr <= '0;
              status <= 4'b0001;
            end
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_WR2: begin
          we <= 1'b1; waddr <= AW'(count - 2'd2); wdata <= opb;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Registered product, used in the cycle after the operands settle.
  always_ff @(posedge clk) begin
    prod <= 64'(opa) * 64'(opb);
  end

endmodule

// ===== rtl/rpn_checker.sv =====
// Port-level checker for the RPN stack calculator, bound to the top level.
module rpn_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        shown,
  input logic [31:0] result_value
);

  // No new item while a result waits.
  a_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("item taken with result pending");

  // A result holds until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  // Results never appear right after acceptance.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid) else $error("result too early");

  // Hidden results carry zero.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !shown |-> result_value == 32'd0) else $error("stray value");

endmodule

bind rpn_stack_calculator rpn_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .shown, .result_value
);
